/* hw/rtl/tgarle_pkg.sv */
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP_TO_BOTTOM = 2'd3;

  // Pixel format codes
  localparam logic [1:0] FMT_BGRA = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;

  // Packet header fields
  localparam logic [7:0] HDR_RUN_BIT  = 8'h80;
  localparam logic [7:0] HDR_CNT_MASK = 8'h7f;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Event passed from the byte parser to the span generator
  typedef struct packed {
    logic       start;    // new image: clear position state
    logic       pixel;    // a pixel was completed
    logic       eop;      // this pixel ends its packet
    logic [7:0] len_req;  // requested span length before clipping
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } evt_t;

endpackage

`default_nettype wire

/* hw/rtl/tgarle_queue.sv */
// ----------------------------------------------------------------------------
// tgarle_queue
// Two-entry register queue between the byte parser and the span generator.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  tgarle_pkg::evt_t    push_evt,
  output logic                full,
  input  wire                 pop,
  output logic                avail,
  output tgarle_pkg::evt_t    head_evt
);

  tgarle_pkg::evt_t mem_r [tgarle_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'(tgarle_pkg::QUEUE_DEPTH));
  assign avail    = (count_r != 2'd0);
  assign head_evt = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tgarle_front.sv */
// ----------------------------------------------------------------------------
// tgarle_front
// Byte parser: tracks packet headers, gathers pixel bytes and emits one event
// per completed pixel or image start.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [1:0]          pixel_format,
  input  wire                 accept,
  input  wire  [7:0]          data_byte,
  input  wire                 image_start,
  output logic                push,
  output tgarle_pkg::evt_t    push_evt
);

  logic [7:0]  packet_left_r, packet_left_nxt;
  logic        packet_is_run_r, packet_is_run_nxt;
  logic [1:0]  byte_in_pixel_r, byte_in_pixel_nxt;
  logic [23:0] pixel_bytes_r, pixel_bytes_nxt;

  // Position state as seen by this byte, after an optional image clear
  logic [7:0]  cur_left;
  logic        cur_run;
  logic [1:0]  cur_bip;
  logic [23:0] cur_bytes;
  logic [2:0]  bpp;
  logic        is_header, is_gather, is_pixel;

  always_comb begin
    cur_left  = image_start ? 8'd0  : packet_left_r;
    cur_run   = image_start ? 1'b0  : packet_is_run_r;
    cur_bip   = image_start ? 2'd0  : byte_in_pixel_r;
    cur_bytes = image_start ? 24'd0 : pixel_bytes_r;

    unique case (pixel_format)
      tgarle_pkg::FMT_BGRA: bpp = 3'd4;
      tgarle_pkg::FMT_BGR:  bpp = 3'd3;
      default:              bpp = 3'd1;
    endcase

    is_header = (cur_left == 8'd0);
    is_gather = !is_header && (({1'b0, cur_bip} + 3'd1) < bpp);
    is_pixel  = !is_header && !is_gather;
  end

  // Classify the byte and update packet state
  always_comb begin
    packet_left_nxt   = cur_left;
    packet_is_run_nxt = cur_run;
    byte_in_pixel_nxt = cur_bip;
    pixel_bytes_nxt   = cur_bytes;

    priority if (is_header) begin
      packet_is_run_nxt = |(data_byte & tgarle_pkg::HDR_RUN_BIT);
      packet_left_nxt   = (data_byte & tgarle_pkg::HDR_CNT_MASK) + 8'd1;
      byte_in_pixel_nxt = 2'd0;
      pixel_bytes_nxt   = 24'd0;
    end else if (is_gather) begin
      pixel_bytes_nxt   = cur_bytes | (24'(data_byte) << {cur_bip, 3'b000});
      byte_in_pixel_nxt = cur_bip + 2'd1;
    end else begin
      byte_in_pixel_nxt = 2'd0;
      pixel_bytes_nxt   = 24'd0;
      packet_left_nxt   = cur_run ? 8'd0 : cur_left - 8'd1;
    end
  end

  // Build the event for the span generator
  always_comb begin
    push_evt.start   = image_start;
    push_evt.pixel   = is_pixel;
    push_evt.eop     = (packet_left_nxt == 8'd0);
    push_evt.len_req = cur_run ? cur_left : 8'd1;
    unique case (pixel_format)
      tgarle_pkg::FMT_BGRA: begin
        push_evt.blue  = cur_bytes[7:0];
        push_evt.green = cur_bytes[15:8];
        push_evt.red   = cur_bytes[23:16];
        push_evt.alpha = data_byte;
      end
      tgarle_pkg::FMT_BGR: begin
        push_evt.blue  = cur_bytes[7:0];
        push_evt.green = cur_bytes[15:8];
        push_evt.red   = data_byte;
        push_evt.alpha = tgarle_pkg::ALPHA_OPAQUE;
      end
      default: begin
        push_evt.blue  = data_byte;
        push_evt.green = data_byte;
        push_evt.red   = data_byte;
        push_evt.alpha = tgarle_pkg::ALPHA_OPAQUE;
      end
    endcase
    push = accept && (image_start || is_pixel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_left_r   <= 8'd0;
      packet_is_run_r <= 1'b0;
      byte_in_pixel_r <= 2'd0;
      pixel_bytes_r   <= 24'd0;
    end else if (accept) begin
      packet_left_r   <= packet_left_nxt;
      packet_is_run_r <= packet_is_run_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      pixel_bytes_r   <= pixel_bytes_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tgarle_back.sv */
// ----------------------------------------------------------------------------
// tgarle_back
// Span generator: clips pixels to the row, tracks column and row, flips rows
// and holds one finished span in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [15:0]         image_width,
  input  wire  [15:0]         image_height,
  input  wire                 top_to_bottom,
  input  wire                 evt_avail,
  input  tgarle_pkg::evt_t    evt,
  output logic                evt_pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_alpha,
  output logic [15:0]         out_row,
  output logic [15:0]         out_start_column,
  output logic [7:0]          out_span_length,
  output logic                out_image_done
);

  logic [15:0] column_pos_r, column_pos_nxt;
  logic [15:0] stored_row_r, stored_row_nxt;
  logic        image_complete_r, image_complete_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [15:0] w_eff, h_eff, room, col_after, row_dst;
  logic [7:0]  len;
  logic [16:0] col_sum;
  logic        emit, last_row, done;

  assign out_valid = out_valid_r;
  assign evt_pop   = evt_avail && (!out_valid_r || !out_stall);

  // Clip and place the span
  always_comb begin
    w_eff    = (image_width == 16'd0) ? 16'd1 : image_width;
    h_eff    = (image_height == 16'd0) ? 16'd1 : image_height;
    room     = w_eff - column_pos_r;
    len      = ({8'd0, evt.len_req} > room) ? room[7:0] : evt.len_req;
    emit     = evt.pixel && !image_complete_r && (column_pos_r < w_eff);
    last_row = ({1'b0, stored_row_r} + 17'd1) >= {1'b0, h_eff};
    col_sum  = {1'b0, column_pos_r} + {9'd0, len};
    done     = last_row && (col_sum >= {1'b0, w_eff});
    col_after = emit ? col_sum[15:0] : column_pos_r;
    row_dst  = top_to_bottom ? stored_row_r : (h_eff - 16'd1 - stored_row_r);
  end

  // Advance column and row
  always_comb begin
    column_pos_nxt     = column_pos_r;
    stored_row_nxt     = stored_row_r;
    image_complete_nxt = image_complete_r;
    if (evt_pop) begin
      priority if (evt.start) begin
        column_pos_nxt     = 16'd0;
        stored_row_nxt     = 16'd0;
        image_complete_nxt = 1'b0;
      end else if (evt.pixel && !image_complete_r) begin
        priority if (emit && done) begin
          column_pos_nxt     = col_after;
          image_complete_nxt = 1'b1;
        end else if (evt.eop && (col_after >= w_eff)) begin
          column_pos_nxt = 16'd0;
          stored_row_nxt = stored_row_r + 16'd1;
          if (last_row) begin
            image_complete_nxt = 1'b1;
          end
        end else begin
          column_pos_nxt = col_after;
        end
      end else begin
        column_pos_nxt = column_pos_r;
      end
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (evt_pop && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_pos_r     <= 16'd0;
      stored_row_r     <= 16'd0;
      image_complete_r <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      column_pos_r     <= column_pos_nxt;
      stored_row_r     <= stored_row_nxt;
      image_complete_r <= image_complete_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Capture span payload
  always_ff @(posedge clk) begin
    if (evt_pop && emit) begin
      out_red          <= evt.red;
      out_green        <= evt.green;
      out_blue         <= evt.blue;
      out_alpha        <= evt.alpha;
      out_row          <= row_dst;
      out_start_column <= column_pos_r;
      out_span_length  <= len;
      out_image_done   <= done;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tga_rle_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decodes a run-length compressed TGA pixel stream, one byte per transaction,
// into RGBA spans placed by row and column.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_stall    in_data_byte, in_image_start
//  out_     output     out_valid / out_stall  out_red..out_alpha, out_row,
//                                             out_start_column,
//                                             out_span_length, out_image_done
//  cfg_     input      cfg_we                 cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; a span is offered once its last byte
// has been written into the queue and then loaded into the output register.
// A two-entry queue between parser and generator lets input stay open while
// an output transaction is stalled; in_stall rises only when the queue fills.
// Reset (synchronous, active low) clears all position state and loads the
// register defaults; no pass over storage is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_image_start,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [15:0] out_row,
  output logic [15:0] out_start_column,
  output logic [7:0]  out_span_length,
  output logic        out_image_done,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  logic [1:0]  pixel_format_r;
  logic [15:0] image_width_r;
  logic [15:0] image_height_r;
  logic        top_to_bottom_r;

  logic             in_accept;
  logic             q_push, q_full, q_pop, q_avail;
  tgarle_pkg::evt_t push_evt, head_evt;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r  <= 2'd0;
      image_width_r   <= 16'd1;
      image_height_r  <= 16'd1;
      top_to_bottom_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgarle_pkg::REG_PIXEL_FORMAT:  pixel_format_r  <= cfg_data[1:0];
        tgarle_pkg::REG_IMAGE_WIDTH:   image_width_r   <= cfg_data;
        tgarle_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data;
        tgarle_pkg::REG_TOP_TO_BOTTOM: top_to_bottom_r <= cfg_data[0];
        default:                       pixel_format_r  <= pixel_format_r;
      endcase
    end
  end

  tgarle_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_format (pixel_format_r),
    .accept       (in_accept),
    .data_byte    (in_data_byte),
    .image_start  (in_image_start),
    .push         (q_push),
    .push_evt     (push_evt)
  );

  tgarle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_evt (push_evt),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_evt (head_evt)
  );

  tgarle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .image_width      (image_width_r),
    .image_height     (image_height_r),
    .top_to_bottom    (top_to_bottom_r),
    .evt_avail        (q_avail),
    .evt              (head_evt),
    .evt_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_row          (out_row),
    .out_start_column (out_start_column),
    .out_span_length  (out_span_length),
    .out_image_done   (out_image_done)
  );

endmodule

`default_nettype wire
